// ----- sv/histl1_pkg.sv -----
// ----------------------------------------------------------------------------
// histl1_pkg
// shared widths, constants and controller/datapath interface types for the
// histogram accumulator with l1 normalization
// ----------------------------------------------------------------------------
package histl1_pkg;

  // fixed field widths
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 8;
  localparam int BIN_W  = 6;
  localparam int FRAC_W = 17;
  localparam int REJ_W  = 16;

  // quotient bits produced by the divider, one per step (q1.16)
  localparam int DIV_STEPS = FRAC_W;

  // controller to datapath
  typedef struct packed {
    logic acc_en;     // accumulate phase, input channel open
    logic k_clr;      // bin counter to zero
    logic k_inc;      // bin counter advance
    logic rd_issue;   // read count of bin k
    logic sum_clr;    // divisor to zero
    logic sum_phase;  // add returning read data into divisor
    logic div_load;   // load divider with returning read data
    logic div_step;   // one restoring division step
    logic out_load;   // load result register
    logic run_clr;    // clear counts and rejected total
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic take_last;  // last item of run accepted this cycle
    logic k_last;     // bin counter is at last active bin
    logic div_last;   // final division step this cycle
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// ----- sv/histogram_accumulate_l1_normalize.sv -----
// ----------------------------------------------------------------------------
// histogram_accumulate_l1_normalize
// bin index histogram with l1 normalization to unsigned q1.16 fractions
// ----------------------------------------------------------------------------
// Each input item carries a bin index. Indices below the active bin count
// (bins_in_use, clamped to 1..MAX_BINS) increment their counter, which
// saturates at all ones; other indices bump a saturating rejected count.
// Ordinary items are taken one per cycle: the counts live in a memory with
// one registered read port and one write port, and a two-stage
// read-modify-write with write forwarding lets the same bin repeat back to
// back. An item marked last closes the run: in_ready drops, the block passes
// a flush state, sums the active bins into the divisor, then for each active
// bin does a memory read, a divider load, 17 divide steps of a shared
// restoring divider and a result hand-off, and ends in a state clearing the
// run. Results come out in bin order with a zero fraction for every bin when
// the divisor is zero. The counts are cleared by per-bin valid bits, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module histogram_accumulate_l1_normalize #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [histl1_pkg::CFG_W-1:0]  cfg_wr_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [histl1_pkg::IDX_W-1:0]  bin_index,
  input  logic                          last_item,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [histl1_pkg::BIN_W-1:0]  bin_number,
  output logic [histl1_pkg::FRAC_W-1:0] bin_fraction,
  output logic [histl1_pkg::REJ_W-1:0]  rejected_items,
  output logic                          last_of_run
);

  histl1_pkg::cmd_t cmd;
  histl1_pkg::sts_t sts;

  // sequencer for accumulate, sum, divide and clear phases
  histl1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // count memory, divisor, divider and result register
  histl1_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .bin_index      (bin_index),
    .last_item      (last_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bin_number     (bin_number),
    .bin_fraction   (bin_fraction),
    .rejected_items (rejected_items),
    .last_of_run    (last_of_run),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- sv/histl1_dp.sv -----
// ----------------------------------------------------------------------------
// histl1_dp
// datapath: count memory with read-modify-write pipeline, divisor sum,
// restoring divider and result register
// ----------------------------------------------------------------------------
module histl1_dp #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [histl1_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  input  logic [histl1_pkg::IDX_W-1:0]      bin_index,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [histl1_pkg::BIN_W-1:0]      bin_number,
  output logic [histl1_pkg::FRAC_W-1:0]     bin_fraction,
  output logic [histl1_pkg::REJ_W-1:0]      rejected_items,
  output logic                              last_of_run,
  input  histl1_pkg::cmd_t                  cmd,
  output histl1_pkg::sts_t                  sts
);

  localparam int ADDR_W = $clog2(MAX_BINS);
  localparam int SUM_W  = COUNT_BITS + ADDR_W;
  localparam int REM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(histl1_pkg::DIV_STEPS);
  localparam logic [histl1_pkg::CFG_W-1:0] MAX_N = histl1_pkg::CFG_W'(MAX_BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [histl1_pkg::REJ_W-1:0] REJ_MAX = {histl1_pkg::REJ_W{1'b1}};

  logic [histl1_pkg::CFG_W-1:0] bins_in_use;
  logic [histl1_pkg::CFG_W-1:0] n_act;
  logic [ADDR_W-1:0]            n_m1;

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]   ent_vld;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_ent_vld;
  logic                  rd_vld;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  logic                  accept;
  logic                  in_range;
  logic                  upd_vld;
  logic [ADDR_W-1:0]     upd_addr;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] upd_val;
  logic                  wr_vld_q;
  logic [ADDR_W-1:0]     wr_addr_q;
  logic [COUNT_BITS-1:0] wr_val_q;

  logic [histl1_pkg::REJ_W-1:0] rejected;
  logic [ADDR_W-1:0]            k;
  logic [COUNT_BITS-1:0]        pass_cnt;
  logic [SUM_W-1:0]             sum;
  logic [REM_W-1:0]             rem;
  logic [REM_W-1:0]             trial;
  logic [histl1_pkg::FRAC_W-1:0] quo;
  logic [STEP_W-1:0]            step;

  // active bin count, clamped to 1..MAX_BINS
  always_comb begin
    priority if (bins_in_use == '0) begin
      n_act = histl1_pkg::CFG_W'(1);
    end else if (bins_in_use > MAX_N) begin
      n_act = MAX_N;
    end else begin
      n_act = bins_in_use;
    end
  end
  assign n_m1 = ADDR_W'(n_act - histl1_pkg::CFG_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= MAX_N;
    end else if (cfg_wr_en) begin
      bins_in_use <= cfg_wr_data;
    end
  end

  assign accept   = in_valid & cmd.acc_en;
  assign in_range = bin_index < histl1_pkg::IDX_W'(n_act);
  assign rd_en    = cmd.rd_issue | (accept & in_range);
  assign rd_addr  = cmd.rd_issue ? k : bin_index[ADDR_W-1:0];

  // count memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_ent_vld <= ent_vld[rd_addr];
    end
    if (upd_vld) begin
      mem[upd_addr] <= upd_val;
    end
  end

  // valid bits stand in for clearing the memory
  always_ff @(posedge clk) begin
    if (rst || cmd.run_clr) begin
      ent_vld <= '0;
    end else if (upd_vld) begin
      ent_vld[upd_addr] <= 1'b1;
    end
  end

  // increment stage, forwarding the write of the previous cycle
  always_comb begin
    priority if (wr_vld_q && (wr_addr_q == upd_addr)) begin
      cur = wr_val_q;
    end else if (ent_vld[upd_addr]) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
  end
  assign upd_val = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_vld  <= 1'b0;
      wr_vld_q <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      upd_vld  <= accept & in_range;
      wr_vld_q <= upd_vld;
      rd_vld   <= cmd.rd_issue;
    end
    if (accept) begin
      upd_addr <= bin_index[ADDR_W-1:0];
    end
    wr_addr_q <= upd_addr;
    wr_val_q  <= upd_val;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.run_clr) begin
      rejected <= '0;
    end else if (accept && !in_range && (rejected != REJ_MAX)) begin
      rejected <= rejected + histl1_pkg::REJ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + ADDR_W'(1);
    end
  end

  assign pass_cnt = rd_ent_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.sum_phase && rd_vld) begin
      sum <= sum + SUM_W'(pass_cnt);
    end
  end

  // restoring divider, one quotient bit per step
  assign trial = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= REM_W'(pass_cnt);
      quo  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      if (trial >= REM_W'(sum)) begin
        rem <= trial - REM_W'(sum);
        quo <= {quo[histl1_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[histl1_pkg::FRAC_W-2:0], 1'b0};
      end
      step <= step + STEP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      bin_number     <= histl1_pkg::BIN_W'(k);
      bin_fraction   <= (sum == '0) ? '0 : quo;
      rejected_items <= rejected;
      last_of_run    <= (k == n_m1);
    end
  end

  assign sts.take_last = accept & last_item;
  assign sts.k_last    = (k == n_m1);
  assign sts.div_last  = (step == STEP_W'(histl1_pkg::DIV_STEPS - 1));
  assign sts.out_free  = ~out_valid | out_ready;

endmodule

// ----- sv/histl1_ctrl.sv -----
// ----------------------------------------------------------------------------
// histl1_ctrl
// controller: sequences accumulation, divisor sum, per-bin division,
// result hand-off and end-of-run clear
// ----------------------------------------------------------------------------
module histl1_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  histl1_pkg::sts_t sts,
  output histl1_pkg::cmd_t cmd,
  output logic             in_ready
);

  localparam logic [3:0] S_ACC     = 4'd0;
  localparam logic [3:0] S_FLUSH   = 4'd1;
  localparam logic [3:0] S_SUM     = 4'd2;
  localparam logic [3:0] S_SUM_END = 4'd3;
  localparam logic [3:0] S_RD      = 4'd4;
  localparam logic [3:0] S_LOAD    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_OUT     = 4'd7;
  localparam logic [3:0] S_CLEAR   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.take_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.k_clr   = 1'b1;
        cmd.sum_clr = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.rd_issue  = 1'b1;
        cmd.sum_phase = 1'b1;
        if (sts.k_last) begin
          cmd.k_clr  = 1'b1;
          state_next = S_SUM_END;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_SUM_END: begin
        cmd.sum_phase = 1'b1;
        state_next    = S_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.k_last) begin
            state_next = S_CLEAR;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd.run_clr = 1'b1;
        state_next  = S_ACC;
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  assign in_ready = (state == S_ACC);

endmodule
